[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, inactive while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/bdsl_pkg.sv]
package bdsl_pkg;

  localparam int unsigned TimeBitsDef = 32;
  localparam int unsigned NowW        = 32;
  localparam int unsigned CfgW        = 16;
  localparam int unsigned EventW      = 2;
  localparam int unsigned ApbAw       = 3;
  localparam int unsigned ApbDw       = 32;
  localparam int unsigned RegSelBit   = 2;

  localparam logic [CfgW-1:0] DebounceRst  = CfgW'(50);
  localparam logic [CfgW-1:0] LongPressRst = CfgW'(1000);

  typedef enum logic {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } reg_idx_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_e;

  typedef struct packed {
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] long_press_time;
  } cfg_t;

endpackage

[sv/bdsl_if.sv]
interface bdsl_in_if;
  import bdsl_pkg::*;

  logic            valid;
  logic            ready;
  logic            button_down;
  logic [NowW-1:0] now_ms;

  modport source (output valid, output button_down, output now_ms, input ready);
  modport sink (input valid, input button_down, input now_ms, output ready);
endinterface

interface bdsl_out_if;
  import bdsl_pkg::*;

  logic              valid;
  logic              ready;
  logic [EventW-1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink (input valid, input press_event, output ready);
endinterface

[sv/bdsl_core.sv]
`include "assert_macros.svh"

module bdsl_core #(
  parameter int unsigned TIME_BITS = bdsl_pkg::TimeBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bdsl_pkg::cfg_t cfg_i,
  bdsl_in_if.sink        in_i,
  bdsl_out_if.source     out_o
);
  import bdsl_pkg::*;

  typedef logic [TIME_BITS-1:0] time_t;

  logic         s1_valid_q;
  logic         s1_down_q;
  time_t        s1_now_q;
  logic         out_valid_q;
  press_event_e out_event_q;
  press_event_e ev_d;

  logic  raw_level_q, raw_level_d;
  logic  stable_level_q, stable_level_d;
  logic  long_fired_q, long_fired_d;
  time_t last_change_q, last_change_d;
  time_t press_start_q, press_start_d;

  time_t since_change;
  time_t since_press;
  logic  s1_fire;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;

  // capture the poll, truncating or widening the timestamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_down_q <= in_i.button_down;
      s1_now_q  <= TIME_BITS'(in_i.now_ms);
    end
  end

  assign since_change = s1_now_q - last_change_q;
  assign since_press  = s1_now_q - press_start_d;

  always_comb begin
    raw_level_d    = raw_level_q;
    stable_level_d = stable_level_q;
    long_fired_d   = long_fired_q;
    last_change_d  = last_change_q;
    press_start_d  = press_start_q;
    ev_d           = EV_NONE;

    if (s1_down_q != raw_level_q) begin
      raw_level_d   = s1_down_q;
      last_change_d = s1_now_q;
    end else if (since_change >= TIME_BITS'(cfg_i.debounce_time) &&
                 s1_down_q != stable_level_q) begin
      stable_level_d = s1_down_q;
      if (s1_down_q) begin
        press_start_d = s1_now_q;
        long_fired_d  = 1'b0;
      end else if (!long_fired_q) begin
        ev_d = EV_SHORT;
      end
    end

    if (stable_level_d && !long_fired_d &&
        since_press >= TIME_BITS'(cfg_i.long_press_time)) begin
      long_fired_d = 1'b1;
      ev_d         = EV_LONG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_level_q    <= 1'b0;
      stable_level_q <= 1'b0;
      long_fired_q   <= 1'b0;
      last_change_q  <= '0;
      press_start_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (s1_fire) begin
        raw_level_q    <= raw_level_d;
        stable_level_q <= stable_level_d;
        long_fired_q   <= long_fired_d;
        last_change_q  <= last_change_d;
        press_start_q  <= press_start_d;
        out_valid_q    <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_event_q <= ev_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.press_event = out_event_q;

  `ASSERT_CLK(a_long_sets_flag, s1_fire && ev_d == EV_LONG |=> long_fired_q,
              "long press reported without setting the fired flag")
  `ASSERT_CLK(a_short_on_release, s1_fire && ev_d == EV_SHORT |=> !stable_level_q,
              "short press reported while still held")
  `ASSERT_CLK(a_raw_change_holds,
              s1_fire && (s1_down_q != raw_level_q) |=> $stable(stable_level_q),
              "stable level changed on a raw level change")
  `ASSERT_ALWAYS(a_out_after_stage, !rst_ni |=> !out_valid_q,
                 "result valid straight out of reset")

endmodule

[sv/button_debounce_short_long_press_top.sv]
// Push-button debouncer with short and long press detection. Each input
// transaction is one poll (button level and millisecond timestamp) and gives
// exactly one result transaction: none, short press (on release) or long press
// (once, while held). One poll is accepted every clock cycle while the result
// side takes results; a poll passes the input register and then the result
// register, with a combinational state update between them. Registers via APB:
// 0x0 debounce time, 0x4 long press time, both in ms, 16 bits; the user treats
// them as writable only while no poll is in flight, unenforced by the block.
module button_debounce_short_long_press_top #(
  parameter int unsigned TIME_BITS = bdsl_pkg::TimeBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdsl_pkg::ApbAw-1:0] paddr,
  input  logic [bdsl_pkg::ApbDw-1:0] pwdata,
  output logic [bdsl_pkg::ApbDw-1:0] prdata,
  output logic                       pready,
  bdsl_in_if.sink                    in_i,
  bdsl_out_if.source                 out_o
);
  import bdsl_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_sel;

  assign reg_sel = reg_idx_e'(paddr[RegSelBit]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= DebounceRst;
      cfg_q.long_press_time <= LongPressRst;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_DEBOUNCE:   cfg_q.debounce_time   <= pwdata[CfgW-1:0];
        REG_LONG_PRESS: cfg_q.long_press_time <= pwdata[CfgW-1:0];
        default:        cfg_q                 <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEBOUNCE:   prdata = ApbDw'(cfg_q.debounce_time);
      REG_LONG_PRESS: prdata = ApbDw'(cfg_q.long_press_time);
      default:        prdata = '0;
    endcase
  end

  bdsl_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .in_i  (in_i),
    .out_o (out_o)
  );

endmodule

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdsl_pkg::*;

  typedef enum logic {
    STEP_POLL,
    STEP_WRITE
  } step_kind_e;

  typedef struct packed {
    step_kind_e      kind;
    reg_idx_e        idx;
    logic            btn;
    logic [NowW-1:0] val;
    logic            typed;
    press_event_e    ev;
  } plan_row_t;

  localparam int unsigned PlanLen    = 29;
  localparam int unsigned Phases     = 8;
  localparam int unsigned PhasePolls = 210;

  plan_row_t plan [PlanLen] = '{
    '{STEP_POLL,  REG_DEBOUNCE,   1'b0, 32'd0,          1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'd10,         1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'd59,         1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'd60,         1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b0, 32'd100,        1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b0, 32'd150,        1'b1, EV_SHORT},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'd200,        1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'd250,        1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'd1249,       1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'd1250,       1'b1, EV_LONG},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b0, 32'd1300,       1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b0, 32'd1350,       1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'hFFFF_FFF0,  1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'h0000_0022,  1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'h0000_0021,  1'b1, EV_LONG},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b0, 32'hFFFF_FFFF,  1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b0, 32'h0000_0031,  1'b1, EV_NONE},
    '{STEP_WRITE, REG_DEBOUNCE,   1'b0, 32'd0,          1'b0, EV_NONE},
    '{STEP_WRITE, REG_LONG_PRESS, 1'b0, 32'd0,          1'b0, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'h1234_5678,  1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'h1234_5678,  1'b1, EV_LONG},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b0, 32'h1234_5679,  1'b1, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b0, 32'h1234_5679,  1'b1, EV_NONE},
    '{STEP_WRITE, REG_DEBOUNCE,   1'b0, 32'd65535,      1'b0, EV_NONE},
    '{STEP_WRITE, REG_LONG_PRESS, 1'b0, 32'd65535,      1'b0, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'h0001_0000,  1'b0, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'h0001_FFFE,  1'b0, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'h0001_FFFF,  1'b0, EV_NONE},
    '{STEP_POLL,  REG_DEBOUNCE,   1'b1, 32'h0002_FFFE,  1'b0, EV_NONE}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ApbAw-1:0] paddr;
  logic [ApbDw-1:0] pwdata;
  logic [ApbDw-1:0] prdata;
  logic             pready;

  bdsl_in_if  poll_if ();
  bdsl_out_if event_if ();

  button_debounce_short_long_press_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (poll_if),
    .out_o   (event_if)
  );

  // predictor state and settings
  logic                   st_raw;
  logic                   st_stable;
  logic                   st_long_fired;
  logic [TimeBitsDef-1:0] st_change_ms;
  logic [TimeBitsDef-1:0] st_press_ms;
  logic [CfgW-1:0]        cfg_debounce;
  logic [CfgW-1:0]        cfg_long_press;

  press_event_e pending_events [$];
  int unsigned  mismatches = 0;
  bit           send_idle = 1'b1;
  bit           sink_idle = 1'b1;
  int unsigned  sink_hold = 0;
  logic [NowW-1:0] clock_ms = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic press_event_e next_press_event(logic btn, logic [NowW-1:0] now_ms);
    logic [TimeBitsDef-1:0] t;
    press_event_e           ev;
    t  = TimeBitsDef'(now_ms);
    ev = EV_NONE;
    if (btn != st_raw) begin
      st_raw       = btn;
      st_change_ms = t;
    end else if (TimeBitsDef'(t - st_change_ms) >= cfg_debounce && btn != st_stable) begin
      st_stable = btn;
      if (btn) begin
        st_press_ms   = t;
        st_long_fired = 1'b0;
      end else if (!st_long_fired) begin
        ev = EV_SHORT;
      end
    end
    if (st_stable && !st_long_fired && TimeBitsDef'(t - st_press_ms) >= cfg_long_press) begin
      st_long_fired = 1'b1;
      ev            = EV_LONG;
    end
    return ev;
  endfunction

  function automatic int unsigned wait_cycles(bit active);
    return active ? $urandom_range(0, 15) : 0;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t: %s", $realtime, what);
  endtask

  task automatic send_poll(logic btn, logic [NowW-1:0] now_ms, logic typed, press_event_e ev);
    int unsigned  gap;
    press_event_e predicted;
    gap = wait_cycles(send_idle);
    if (gap > 0) begin
      poll_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    poll_if.valid       <= 1'b1;
    poll_if.button_down <= btn;
    poll_if.now_ms      <= now_ms;
    do @(posedge clk_i); while (!poll_if.ready);
    predicted = next_press_event(btn, now_ms);
    pending_events.push_back(typed ? ev : predicted);
  endtask

  task automatic drain();
    poll_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_register(reg_idx_e idx, logic [CfgW-1:0] val);
    logic [ApbDw-1:0] word;
    drain();
    word           = $urandom;
    word[CfgW-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAw'(idx) << RegSelBit;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DEBOUNCE) cfg_debounce = val;
    else cfg_long_press = val;
  endtask

  task automatic run_phase(int unsigned polls);
    logic [CfgW-1:0] deb;
    logic [CfgW-1:0] lp;
    int unsigned     scale;
    int unsigned     left;
    int unsigned     pause_at;
    logic            level;
    logic            btn;
    logic [NowW-1:0] now_ms;
    case ($urandom_range(0, 4))
      0:       deb = '0;
      1:       deb = '1;
      2:       deb = CfgW'($urandom_range(0, 65535));
      default: deb = CfgW'($urandom_range(1, 200));
    endcase
    case ($urandom_range(0, 4))
      0:       lp = '0;
      1:       lp = '1;
      2:       lp = CfgW'($urandom_range(0, 65535));
      default: lp = CfgW'($urandom_range(0, 3000));
    endcase
    set_register(REG_DEBOUNCE, deb);
    set_register(REG_LONG_PRESS, lp);
    send_idle = $urandom_range(0, 2) != 0;
    sink_idle = $urandom_range(0, 2) != 0;
    scale     = ((deb > lp) ? deb : lp) / 3 + 1;
    left      = 0;
    level     = st_stable;
    pause_at  = $urandom_range(0, polls - 1);
    for (int unsigned k = 0; k < polls; k++) begin
      if (left == 0) begin
        level = ~level;
        left  = $urandom_range(2, 12);
      end
      left--;
      btn = level;
      // contact bounce
      if ($urandom_range(0, 3) == 0) btn = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 11))
        0:       now_ms = $urandom;
        1:       now_ms = NowW'(st_change_ms + cfg_debounce - $urandom_range(0, 1));
        2:       now_ms = NowW'(st_press_ms + cfg_long_press - $urandom_range(0, 1));
        default: now_ms = clock_ms + $urandom_range(0, scale);
      endcase
      clock_ms = now_ms;
      send_poll(btn, now_ms, 1'b0, EV_NONE);
      if (k == pause_at) drain();
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      event_if.ready <= 1'b0;
    end else begin
      if (event_if.valid && event_if.ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event %0d", event_if.press_event));
        end else begin
          if (event_if.press_event !== pending_events[0]) begin
            report_mismatch($sformatf("press_event %0d, expected %0d",
                                      event_if.press_event, pending_events[0]));
          end
          void'(pending_events.pop_front());
        end
        sink_hold = wait_cycles(sink_idle);
      end
      if (sink_hold > 0) begin
        event_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        event_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    poll_if.valid       <= 1'b0;
    poll_if.button_down <= 1'b0;
    poll_if.now_ms      <= '0;
    st_raw         = 1'b0;
    st_stable      = 1'b0;
    st_long_fired  = 1'b0;
    st_change_ms   = '0;
    st_press_ms    = '0;
    cfg_debounce   = DebounceRst;
    cfg_long_press = LongPressRst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < PlanLen; i++) begin
      if (plan[i].kind == STEP_WRITE) begin
        set_register(plan[i].idx, plan[i].val[CfgW-1:0]);
      end else begin
        send_poll(plan[i].btn, plan[i].val, plan[i].typed, plan[i].ev);
      end
    end

    for (int unsigned p = 0; p < Phases; p++) run_phase(PhasePolls);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
